>>> design/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and types of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 3'd0,
    FN_DELETE  = 3'd1,
    FN_GET     = 3'd2,
    FN_LOCATE  = 3'd3,
    FN_REVERSE = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2,
    SH_ROTATE = 2'd3
  } shift_e;

  typedef struct packed {
    shift_e           op;
    logic [IDX_W-1:0] idx;
  } shift_t;

endpackage

>>> design/sle_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_req_if
// Request channel: operation code, list position and value.
// ----------------------------------------------------------------------------
interface sle_req_if;
  logic                                valid;
  logic                                ready;
  logic [sle_pkg::FUNC_W-1:0]          func;
  logic [sle_pkg::POS_W-1:0]           position;
  logic signed [sle_pkg::DATA_W-1:0]   value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

>>> design/sle_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_rsp_if
// Response channel: status, read data, match position and list length.
// ----------------------------------------------------------------------------
interface sle_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [sle_pkg::STAT_W-1:0]          status;
  logic signed [sle_pkg::DATA_W-1:0]   data_out;
  logic [sle_pkg::CNT_W-1:0]           found_position;
  logic [sle_pkg::CNT_W-1:0]           count;

  modport source (output valid, status, data_out, found_position, count, input ready);
  modport sink   (input valid, status, data_out, found_position, count, output ready);
endinterface

>>> design/sle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, shifts it to or takes it from its neighbors
// and compares it against the broadcast search value.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic                        clk_i,
  input  sle_pkg::shift_t             shift_i,
  input  logic [sle_pkg::IDX_W-1:0]   idx_i,
  input  sle_pkg::word_t              left_i,
  input  sle_pkg::word_t              right_i,
  input  sle_pkg::word_t              head_i,
  input  sle_pkg::word_t              value_i,
  output sle_pkg::word_t              data_o,
  output logic                        match_o
);

  sle_pkg::word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (shift_i.op)
      sle_pkg::SH_INSERT: begin
        if (idx_i == shift_i.idx) begin
          data_d = value_i;
        end else if (idx_i > shift_i.idx) begin
          data_d = left_i;
        end
      end
      sle_pkg::SH_DELETE: begin
        if (idx_i >= shift_i.idx) begin
          data_d = right_i;
        end
      end
      sle_pkg::SH_ROTATE: begin
        if (idx_i == shift_i.idx) begin
          data_d = head_i;
        end else if (idx_i < shift_i.idx) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule

>>> design/sle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: takes requests, checks positions against the length, drives
// the cell row shifts and holds the response register.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  sle_req_if.sink                                         req_i,
  sle_rsp_if.source                                       rsp_o,
  input  logic [sle_pkg::DEPTH-1:0][sle_pkg::DATA_W-1:0]  cell_data_i,
  input  logic [sle_pkg::DEPTH-1:0]                       match_i,
  output sle_pkg::shift_t                                 shift_o,
  output sle_pkg::word_t                                  value_o
);

  localparam int unsigned CW = ((sle_pkg::POS_W > sle_pkg::LEN_W) ?
                                sle_pkg::POS_W : sle_pkg::LEN_W) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_REV  = 5'b00100,
    S_FIND = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [sle_pkg::LEN_W-1:0]       len_q, len_d;
  logic [sle_pkg::FUNC_W-1:0]      func_q, func_d;
  logic [sle_pkg::POS_W-1:0]       pos_q, pos_d;
  sle_pkg::word_t                  value_q, value_d;
  logic [sle_pkg::IDX_W-1:0]       end_q, end_d;
  logic [sle_pkg::DEPTH-1:0]       match_q, match_d;
  sle_pkg::status_e                res_status_q, res_status_d;
  sle_pkg::word_t                  res_data_q, res_data_d;
  logic [sle_pkg::CNT_W-1:0]       res_found_q, res_found_d;
  logic                            out_valid_q, out_valid_d;
  sle_pkg::status_e                out_status_q, out_status_d;
  sle_pkg::word_t                  out_data_q, out_data_d;
  logic [sle_pkg::CNT_W-1:0]       out_found_q, out_found_d;
  logic [sle_pkg::CNT_W-1:0]       out_count_q, out_count_d;

  logic [sle_pkg::IDX_W-1:0]       slot;
  logic [CW-1:0]                   pos_ext, len_ext;
  logic [sle_pkg::DEPTH-1:0]       live;
  logic [sle_pkg::CNT_W-1:0]       first_hit;
  sle_pkg::shift_t                 shift;

  always_comb begin
    slot    = sle_pkg::IDX_W'(pos_q - 1'b1);
    pos_ext = CW'(pos_q);
    len_ext = CW'(len_q);
    for (int i = 0; i < sle_pkg::DEPTH; i++) begin
      live[i] = (sle_pkg::LEN_W'(i) < len_q);
    end
    first_hit = '0;
    for (int i = sle_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_hit = sle_pkg::CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    func_d       = func_q;
    pos_d        = pos_q;
    value_d      = value_q;
    end_d        = end_q;
    match_d      = match_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    shift        = '{op: sle_pkg::SH_HOLD, idx: '0};

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          pos_d   = req_i.position;
          value_d = sle_pkg::word_t'(req_i.value);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = sle_pkg::STAT_OK;
        res_data_d   = '0;
        res_found_d  = '0;
        state_d      = S_RESP;
        case (sle_pkg::func_e'(func_q))
          sle_pkg::FN_INSERT: begin
            if (pos_q == '0 || pos_ext > len_ext + 1'b1) begin
              res_status_d = sle_pkg::STAT_BADPOS;
            end else if (len_ext == CW'(sle_pkg::DEPTH)) begin
              res_status_d = sle_pkg::STAT_FULL;
            end else begin
              shift = '{op: sle_pkg::SH_INSERT, idx: slot};
              len_d = sle_pkg::LEN_W'(len_q + 1'b1);
            end
          end
          sle_pkg::FN_DELETE: begin
            if (pos_q == '0 || pos_ext > len_ext) begin
              res_status_d = sle_pkg::STAT_BADPOS;
            end else begin
              res_data_d = cell_data_i[slot];
              shift      = '{op: sle_pkg::SH_DELETE, idx: slot};
              len_d      = sle_pkg::LEN_W'(len_q - 1'b1);
            end
          end
          sle_pkg::FN_GET: begin
            if (pos_q == '0 || pos_ext > len_ext) begin
              res_status_d = sle_pkg::STAT_BADPOS;
            end else begin
              res_data_d = cell_data_i[slot];
            end
          end
          sle_pkg::FN_LOCATE: begin
            match_d = match_i & live;
            state_d = S_FIND;
          end
          sle_pkg::FN_REVERSE: begin
            if (len_ext >= CW'(2)) begin
              end_d   = sle_pkg::IDX_W'(len_q - 1'b1);
              state_d = S_REV;
            end
          end
          default: begin
            res_status_d = sle_pkg::STAT_OK;
          end
        endcase
      end
      S_REV: begin
        // move the head entry behind the shrinking tail
        shift = '{op: sle_pkg::SH_ROTATE, idx: end_q};
        end_d = end_q - 1'b1;
        if (end_q == sle_pkg::IDX_W'(1)) begin
          state_d = S_RESP;
        end
      end
      S_FIND: begin
        if (first_hit == '0) begin
          res_status_d = sle_pkg::STAT_NOTFOUND;
        end else begin
          res_found_d = first_hit;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_found_d  = res_found_q;
          out_count_d  = sle_pkg::CNT_W'(len_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    pos_q        <= pos_d;
    value_q      <= value_d;
    end_q        <= end_d;
    match_q      <= match_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.data_out       = $signed(out_data_q);
  assign rsp_o.found_position = out_found_q;
  assign rsp_o.count          = out_count_q;
  assign shift_o              = shift;
  assign value_o              = value_q;

endmodule

>>> design/sequential_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_unit
// Ordered list of signed words held in a row of cells, with insert, delete,
// get, locate and reverse requests.
// ----------------------------------------------------------------------------
// Insert, delete, get and unused codes pass the sequencer states EXEC and
//   RESP; locate passes EXEC, FIND and RESP, and a reverse of two or more
//   entries loops in REV between EXEC and RESP. A request is taken the cycle
//   after its predecessor's response is registered, and none while another
//   is in flight; a stalled response holds the sequencer until it is taken.
// Reset clears the length, the sequencer and the response valid; cell contents
//   are not reset.
module sequential_list_engine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_req_if.sink    req_i,
  sle_rsp_if.source  rsp_o
);

  logic [sle_pkg::DEPTH-1:0][sle_pkg::DATA_W-1:0] cell_data;
  logic [sle_pkg::DEPTH-1:0]                      match;
  sle_pkg::shift_t                                shift;
  sle_pkg::word_t                                 value;

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cell_data_i (cell_data),
    .match_i     (match),
    .shift_o     (shift),
    .value_o     (value)
  );

  for (genvar g = 0; g < sle_pkg::DEPTH; g++) begin : g_cell
    sle_pkg::word_t left, right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end

    if (g == sle_pkg::DEPTH - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    sle_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .idx_i   (sle_pkg::IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_data[0]),
      .value_i (value),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

endmodule

>>> design/sle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the response channel of the list engine.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic [sle_pkg::STAT_W-1:0]         rsp_status_i,
  input logic signed [sle_pkg::DATA_W-1:0]  rsp_data_out_i,
  input logic [sle_pkg::CNT_W-1:0]          rsp_found_position_i,
  input logic [sle_pkg::CNT_W-1:0]          rsp_count_i
);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_count_i <= sle_pkg::CNT_W'(sle_pkg::DEPTH)))
    else $error("count above list depth");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i != sle_pkg::STAT_OK) |->
      (rsp_data_out_i == '0 && rsp_found_position_i == '0))
    else $error("failed request carries data or position");

  a_found_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_found_position_i != '0) |->
      (rsp_found_position_i <= rsp_count_i && rsp_data_out_i == '0))
    else $error("match position outside list");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_data_out_i) &&
       $stable(rsp_found_position_i) && $stable(rsp_count_i)))
    else $error("stalled response changed");

endmodule

bind sequential_list_engine_unit sle_checker u_sle_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_status_i         (rsp_o.status),
  .rsp_data_out_i       (rsp_o.data_out),
  .rsp_found_position_i (rsp_o.found_position),
  .rsp_count_i          (rsp_o.count)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sequential list engine. A directed table covers
// the empty list, bad positions, value extremes, reverse, locate and unused
// codes, then random request streams that fill and drain the list run under
// several sender and receiver idle mixes, including one long response hold.
// Every response is checked field by field, in order, against the directed
// table's expected fields or an in-order predictor.
module tb;

  localparam logic [sle_pkg::FUNC_W-1:0] FN_SPARE5 = 3'd5;
  localparam logic [sle_pkg::FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [sle_pkg::FUNC_W-1:0] FN_SPARE7 = 3'd7;
  localparam int N_DIR        = 25;
  localparam int N_RAND       = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    sle_pkg::status_e          status;
    sle_pkg::word_t            data;
    logic [sle_pkg::CNT_W-1:0] fpos;
    logic [sle_pkg::CNT_W-1:0] count;
  } list_rsp_t;

  typedef struct {
    logic [sle_pkg::FUNC_W-1:0] fn;
    logic [sle_pkg::POS_W-1:0]  pos;
    sle_pkg::word_t             val;
    bit                         typed;
    sle_pkg::status_e           st;
    sle_pkg::word_t             data;
    logic [sle_pkg::CNT_W-1:0]  fpos;
    logic [sle_pkg::CNT_W-1:0]  cnt;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sle_req_if req_if ();
  sle_rsp_if rsp_if ();

  sequential_list_engine_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sle_pkg::word_t list_mem [sle_pkg::DEPTH];
  int             list_len;
  list_rsp_t      expected_rsp_q [$];
  int             mismatch_cnt;
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_rsp_req;
  row_t           dir_rows [N_DIR];

  function automatic list_rsp_t apply_list_op(logic [sle_pkg::FUNC_W-1:0] fn,
                                              logic [sle_pkg::POS_W-1:0] pos,
                                              sle_pkg::word_t val);
    list_rsp_t      r;
    int             p;
    int             i;
    int             lo;
    int             hi;
    sle_pkg::word_t t;
    r = '{status: sle_pkg::STAT_OK, data: '0, fpos: '0, count: '0};
    p = int'(pos);
    case (fn)
      sle_pkg::FN_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = sle_pkg::STAT_BADPOS;
        end else if (list_len >= int'(sle_pkg::DEPTH)) begin
          r.status = sle_pkg::STAT_FULL;
        end else begin
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      sle_pkg::FN_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = sle_pkg::STAT_BADPOS;
        end else begin
          r.data = list_mem[p-1];
          for (i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      sle_pkg::FN_GET: begin
        if (p < 1 || p > list_len) r.status = sle_pkg::STAT_BADPOS;
        else r.data = list_mem[p-1];
      end
      sle_pkg::FN_LOCATE: begin
        r.status = sle_pkg::STAT_NOTFOUND;
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_mem[i] == val) begin
            r.status = sle_pkg::STAT_OK;
            r.fpos   = sle_pkg::CNT_W'(i + 1);
          end
        end
      end
      sle_pkg::FN_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (lo < hi) begin
          t            = list_mem[lo];
          list_mem[lo] = list_mem[hi];
          list_mem[hi] = t;
          lo++;
          hi--;
        end
      end
      default: ;
    endcase
    r.count = sle_pkg::CNT_W'(list_len);
    return r;
  endfunction

  task automatic offer_request(input logic [sle_pkg::FUNC_W-1:0] fn,
                               input logic [sle_pkg::POS_W-1:0] pos,
                               input sle_pkg::word_t val, input bit typed,
                               input list_rsp_t typed_rsp);
    list_rsp_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.func     = fn;
    req_if.position = pos;
    req_if.value    = val;
    do @(posedge clk_i); while (!req_if.ready);
    pred = apply_list_op(fn, pos, val);
    expected_rsp_q.push_back(typed ? typed_rsp : pred);
  endtask

  // response side: stall, long hold, check
  initial begin
    list_rsp_t e;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp_req) begin
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_rsp_req = 1'b0;
      end
      rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t ERROR: unexpected response st=%0d data=%h fpos=%0d cnt=%0d", $time,
                   rsp_if.status, rsp_if.data_out, rsp_if.found_position, rsp_if.count);
          mismatch_cnt++;
        end else begin
          e = expected_rsp_q.pop_front();
          if (rsp_if.status !== e.status || rsp_if.data_out !== e.data ||
              rsp_if.found_position !== e.fpos || rsp_if.count !== e.count) begin
            $display("%0t ERROR: expected st=%0d data=%h fpos=%0d cnt=%0d", $time,
                     e.status, e.data, e.fpos, e.count);
            $display("%0t ERROR:   actual st=%0d data=%h fpos=%0d cnt=%0d", $time,
                     rsp_if.status, rsp_if.data_out, rsp_if.found_position, rsp_if.count);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("sequential_list_engine_unit verification failed");
    $finish;
  end

  initial begin
    list_rsp_t                  tr;
    logic [sle_pkg::FUNC_W-1:0] fn;
    logic [sle_pkg::POS_W-1:0]  pos;
    sle_pkg::word_t             val;
    int                         k;
    int                         pct;
    bit                         fill_mode;
    req_if.valid    = 1'b0;
    req_if.func     = '0;
    req_if.position = '0;
    req_if.value    = '0;
    rst_ni          = 1'b0;
    mismatch_cnt    = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_rsp_req    = 1'b0;
    list_len        = 0;
    fill_mode       = 1'b1;
    foreach (list_mem[i]) list_mem[i] = '0;

    dir_rows = '{
      '{sle_pkg::FN_GET, 5'd1, 32'd0, 1'b1, sle_pkg::STAT_BADPOS, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_DELETE, 5'd0, 32'd0, 1'b1, sle_pkg::STAT_BADPOS, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_LOCATE, 5'd0, 32'd5, 1'b1, sle_pkg::STAT_NOTFOUND, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_REVERSE, 5'd0, 32'd0, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_INSERT, 5'd0, 32'd1, 1'b1, sle_pkg::STAT_BADPOS, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_INSERT, 5'd2, 32'd1, 1'b1, sle_pkg::STAT_BADPOS, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_INSERT, 5'd1, 32'h80000000, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd1},
      '{sle_pkg::FN_INSERT, 5'd2, 32'h7fffffff, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd2},
      '{sle_pkg::FN_INSERT, 5'd3, 32'hffffffff, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd3},
      '{sle_pkg::FN_INSERT, 5'd1, 32'd0, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd4},
      '{sle_pkg::FN_GET, 5'd1, 32'd0, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd4},
      '{sle_pkg::FN_GET, 5'd4, 32'd0, 1'b1, sle_pkg::STAT_OK, 32'hffffffff, 5'd0, 5'd4},
      '{sle_pkg::FN_GET, 5'd31, 32'd0, 1'b1, sle_pkg::STAT_BADPOS, 32'd0, 5'd0, 5'd4},
      '{sle_pkg::FN_INSERT, 5'd31, 32'd9, 1'b1, sle_pkg::STAT_BADPOS, 32'd0, 5'd0, 5'd4},
      '{sle_pkg::FN_REVERSE, 5'd0, 32'd0, 1'b0, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_GET, 5'd1, 32'd0, 1'b1, sle_pkg::STAT_OK, 32'hffffffff, 5'd0, 5'd4},
      '{sle_pkg::FN_LOCATE, 5'd0, 32'h80000000, 1'b0, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_LOCATE, 5'd0, 32'd12345, 1'b1, sle_pkg::STAT_NOTFOUND, 32'd0, 5'd0, 5'd4},
      '{FN_SPARE5, 5'd1, 32'd7, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd4},
      '{FN_SPARE6, 5'd2, 32'h80000000, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd4},
      '{FN_SPARE7, 5'd31, 32'hffffffff, 1'b1, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd4},
      '{sle_pkg::FN_DELETE, 5'd5, 32'd0, 1'b1, sle_pkg::STAT_BADPOS, 32'd0, 5'd0, 5'd4},
      '{sle_pkg::FN_DELETE, 5'd2, 32'd0, 1'b1, sle_pkg::STAT_OK, 32'h7fffffff, 5'd0, 5'd3},
      '{sle_pkg::FN_INSERT, 5'd2, 32'd0, 1'b0, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd0},
      '{sle_pkg::FN_LOCATE, 5'd0, 32'd0, 1'b0, sle_pkg::STAT_OK, 32'd0, 5'd0, 5'd0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < N_DIR; k++) begin
      tr = '{status: dir_rows[k].st, data: dir_rows[k].data, fpos: dir_rows[k].fpos,
             count: dir_rows[k].cnt};
      offer_request(dir_rows[k].fn, dir_rows[k].pos, dir_rows[k].val, dir_rows[k].typed, tr);
    end

    for (k = 0; k < N_RAND; k++) begin
      case (k / 238)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (k == 100) hold_rsp_req = 1'b1;

      pct = $urandom_range(99);
      if (fill_mode) begin
        if (pct < 55)      fn = sle_pkg::FN_INSERT;
        else if (pct < 65) fn = sle_pkg::FN_DELETE;
        else if (pct < 77) fn = sle_pkg::FN_GET;
        else if (pct < 89) fn = sle_pkg::FN_LOCATE;
        else if (pct < 95) fn = sle_pkg::FN_REVERSE;
        else               fn = sle_pkg::FUNC_W'($urandom_range(5, 7));
      end else begin
        if (pct < 45)      fn = sle_pkg::FN_DELETE;
        else if (pct < 55) fn = sle_pkg::FN_INSERT;
        else if (pct < 70) fn = sle_pkg::FN_GET;
        else if (pct < 85) fn = sle_pkg::FN_LOCATE;
        else if (pct < 93) fn = sle_pkg::FN_REVERSE;
        else               fn = sle_pkg::FUNC_W'($urandom_range(5, 7));
      end

      pos = sle_pkg::POS_W'($urandom_range(31));
      if ($urandom_range(99) >= 12) begin
        if (fn == sle_pkg::FN_INSERT) pos = sle_pkg::POS_W'($urandom_range(1, list_len + 1));
        else if ((fn == sle_pkg::FN_DELETE || fn == sle_pkg::FN_GET) && list_len > 0)
          pos = sle_pkg::POS_W'($urandom_range(1, list_len));
      end

      case ($urandom_range(9))
        0:       val = 32'h80000000;
        1:       val = 32'h7fffffff;
        2, 3, 4: val = sle_pkg::word_t'($urandom_range(7));
        default: val = $urandom;
      endcase
      if (fn == sle_pkg::FN_LOCATE && list_len > 0 && $urandom_range(99) < 65)
        val = list_mem[$urandom_range(list_len - 1)];

      offer_request(fn, pos, val, 1'b0, tr);

      if (list_len == int'(sle_pkg::DEPTH) && $urandom_range(3) == 0) fill_mode = 1'b0;
      if (list_len == 0 && $urandom_range(3) == 0) fill_mode = 1'b1;
    end

    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("sequential_list_engine_unit verification clean");
    end else begin
      $display("sequential_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sle_pkg.sv
design/sle_req_if.sv
design/sle_rsp_if.sv
design/sle_cell.sv
design/sle_ctrl.sv
design/sequential_list_engine_unit.sv
design/sle_checker.sv
bench/tb.sv
